// ===== rtl/lrur_pkg.sv =====
// Shared types and codes for the LRU frame replacer with pin counts.
package lrur_pkg;

    localparam int FRAME_W = 6;
    localparam int FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_VICTIM = 2'd0,
        FUNC_PIN    = 2'd1,
        FUNC_UNPIN  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_LINK,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/lru_replacer_with_pin_counts_core.sv =====
// LRU frame replacer with pin counts: sequencer over frame state and link tables.
//
//   channel  dir  tdata                      tuser
//   s_       in   [5:0] frame                [1:0] func
//   m_       out  [5:0] victim_frame         [0] found, [1] error
//
// Fresh or empty-list victim, no-op or out-of-range frame: IDLE accepts, RESP
// responds. Pin, unpin and list victim: READ, EVAL, LINK when the LRU list is
// relinked, then RESP; the link tables are read in READ and the neighbors
// written in LINK. After reset a clearing pass zeroes the pin counts; no word
// is accepted meanwhile. A stalled output holds the next result in the sequencer.
module lru_replacer_with_pin_counts_core #(
    parameter int FRAMES   = 64,
    parameter int PIN_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [5:0] frame, [7:6] zero
    input  logic [1:0] s_tuser,   // [1:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] victim_frame, [7:6] zero
    output logic [1:0] m_tuser    // [0] found, [1] error
);

    localparam int FIDX = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW   = $clog2(FRAMES + 1);
    localparam int WW   = FIDX + lrur_pkg::FRAME_W;
    localparam int SW   = PIN_BITS + 1;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
    localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

    lrur_pkg::state_t state_reg, state_next;
    lrur_pkg::func_t  func_reg, func_next;
    logic [FIDX-1:0]  op_frame_reg, op_frame_next;
    logic             op_append_reg, op_append_next;
    logic [FIDX-1:0]  res_victim_reg, res_victim_next;
    logic             res_found_reg, res_found_next;
    logic             res_error_reg, res_error_next;
    logic [FIDX-1:0]  oldest_reg, oldest_next;
    logic [FIDX-1:0]  newest_reg, newest_next;
    logic             empty_reg, empty_next;
    logic [CW-1:0]    fresh_reg, fresh_next;
    logic [FIDX-1:0]  clr_idx_reg, clr_idx_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    logic [SW-1:0]    state_mem [FRAMES];
    logic [FIDX-1:0]  prev_mem  [FRAMES];
    logic [FIDX-1:0]  next_mem  [FRAMES];
    logic [SW-1:0]    st_rd_reg;
    logic [FIDX-1:0]  prev_rd_reg;
    logic [FIDX-1:0]  next_rd_reg;

    logic             rd_en;
    logic             st_we;
    logic [FIDX-1:0]  st_waddr;
    logic [SW-1:0]    st_wdata;
    logic             prev_we;
    logic [FIDX-1:0]  prev_waddr;
    logic [FIDX-1:0]  prev_wdata;
    logic             next_we;
    logic [FIDX-1:0]  next_waddr;
    logic [FIDX-1:0]  next_wdata;

    lrur_pkg::func_t  s_func;
    logic [WW-1:0]    frame_wide;
    logic             frame_ok;
    logic [FIDX-1:0]  frame_idx;
    logic             accept;
    logic             fresh_avail;
    logic             out_free;
    logic             clr_last;
    logic [WW-1:0]    vic_wide;

    logic [PIN_BITS-1:0] st_pin;
    logic                st_in;
    logic                ev_wr;
    logic [SW-1:0]       ev_wdata;
    logic                ev_link;
    logic                ev_append;
    logic                ev_error;
    logic                ev_found;

    assign s_func      = lrur_pkg::func_t'(s_tuser);
    assign frame_wide  = {{FIDX{1'b0}}, s_tdata[lrur_pkg::FRAME_W-1:0]};
    assign frame_ok    = frame_wide < WW'(FRAMES);
    assign frame_idx   = frame_wide[FIDX-1:0];
    assign s_tready    = (state_reg == lrur_pkg::ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign fresh_avail = fresh_reg < CW'(FRAMES);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign clr_last    = clr_idx_reg == FIDX'(FRAMES - 1);
    assign vic_wide    = {{lrur_pkg::FRAME_W{1'b0}}, res_victim_reg};

    assign st_pin = st_rd_reg[PIN_BITS-1:0];
    assign st_in  = st_rd_reg[PIN_BITS];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // decision on the frame state read back
    always_comb begin
        ev_wr     = 1'b0;
        ev_wdata  = st_rd_reg;
        ev_link   = 1'b0;
        ev_append = 1'b0;
        ev_error  = 1'b0;
        ev_found  = 1'b0;
        case (func_reg)
            lrur_pkg::FUNC_VICTIM: begin
                ev_wr    = 1'b1;
                ev_wdata = {1'b0, st_pin};
                ev_link  = 1'b1;
                ev_found = 1'b1;
            end
            lrur_pkg::FUNC_PIN: begin
                if (st_pin == PIN_MAX) begin
                    ev_error = 1'b1;
                end else begin
                    ev_wr    = 1'b1;
                    ev_wdata = {st_in && (st_pin != '0), st_pin + PIN_ONE};
                    ev_link  = st_in && (st_pin == '0);
                end
            end
            lrur_pkg::FUNC_UNPIN: begin
                if (st_pin == '0) begin
                    ev_error = 1'b1;
                end else if (st_pin == PIN_ONE && !st_in) begin
                    ev_wr     = 1'b1;
                    ev_wdata  = {1'b1, {PIN_BITS{1'b0}}};
                    ev_link   = 1'b1;
                    ev_append = 1'b1;
                end else begin
                    ev_wr    = 1'b1;
                    ev_wdata = {st_in, st_pin - PIN_ONE};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrur_pkg::ST_CLEAR: begin
                if (clr_last) state_next = lrur_pkg::ST_IDLE;
            end
            lrur_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = lrur_pkg::ST_RESP;
                    case (s_func) inside
                        lrur_pkg::FUNC_VICTIM: begin
                            if (!fresh_avail && !empty_reg) state_next = lrur_pkg::ST_READ;
                        end
                        lrur_pkg::FUNC_PIN, lrur_pkg::FUNC_UNPIN: begin
                            if (frame_ok) state_next = lrur_pkg::ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lrur_pkg::ST_READ: state_next = lrur_pkg::ST_EVAL;
            lrur_pkg::ST_EVAL: begin
                state_next = ev_link ? lrur_pkg::ST_LINK : lrur_pkg::ST_RESP;
            end
            lrur_pkg::ST_LINK: state_next = lrur_pkg::ST_RESP;
            lrur_pkg::ST_RESP: begin
                if (out_free) state_next = lrur_pkg::ST_IDLE;
            end
            default: state_next = lrur_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        func_next       = func_reg;
        op_frame_next   = op_frame_reg;
        op_append_next  = op_append_reg;
        res_victim_next = res_victim_reg;
        res_found_next  = res_found_reg;
        res_error_next  = res_error_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        empty_next      = empty_reg;
        fresh_next      = fresh_reg;
        clr_idx_next    = clr_idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        rd_en           = 1'b0;
        st_we           = 1'b0;
        st_waddr        = op_frame_reg;
        st_wdata        = ev_wdata;
        prev_we         = 1'b0;
        prev_waddr      = op_frame_reg;
        prev_wdata      = '0;
        next_we         = 1'b0;
        next_waddr      = op_frame_reg;
        next_wdata      = '0;
        unique case (state_reg)
            lrur_pkg::ST_CLEAR: begin
                st_we        = 1'b1;
                st_waddr     = clr_idx_reg;
                st_wdata     = '0;
                clr_idx_next = clr_idx_reg + FIDX'(1);
            end
            lrur_pkg::ST_IDLE: begin
                if (accept) begin
                    func_next       = s_func;
                    op_frame_next   = frame_idx;
                    res_victim_next = '0;
                    res_found_next  = 1'b0;
                    res_error_next  = 1'b0;
                    if (s_func == lrur_pkg::FUNC_VICTIM) begin
                        if (fresh_avail) begin
                            res_victim_next = fresh_reg[FIDX-1:0];
                            res_found_next  = 1'b1;
                            fresh_next      = fresh_reg + CW'(1);
                        end else begin
                            op_frame_next = oldest_reg;
                        end
                    end
                end
            end
            lrur_pkg::ST_READ: rd_en = 1'b1;
            lrur_pkg::ST_EVAL: begin
                st_we          = ev_wr;
                op_append_next = ev_append;
                res_error_next = ev_error;
                res_found_next = ev_found;
                if (ev_found) res_victim_next = op_frame_reg;
            end
            lrur_pkg::ST_LINK: begin
                if (op_append_reg) begin
                    if (empty_reg) begin
                        oldest_next = op_frame_reg;
                        empty_next  = 1'b0;
                        prev_we     = 1'b1;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = newest_reg;
                        next_wdata = op_frame_reg;
                        prev_we    = 1'b1;
                        prev_wdata = newest_reg;
                    end
                    newest_next = op_frame_reg;
                end else if (op_frame_reg == oldest_reg && op_frame_reg == newest_reg) begin
                    empty_next  = 1'b1;
                    oldest_next = '0;
                    newest_next = '0;
                end else if (op_frame_reg == oldest_reg) begin
                    oldest_next = next_rd_reg;
                    prev_we     = 1'b1;
                    prev_waddr  = next_rd_reg;
                end else if (op_frame_reg == newest_reg) begin
                    newest_next = prev_rd_reg;
                    next_we     = 1'b1;
                    next_waddr  = prev_rd_reg;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg;
                    next_wdata = next_rd_reg;
                    prev_we    = 1'b1;
                    prev_waddr = next_rd_reg;
                    prev_wdata = prev_rd_reg;
                end
            end
            lrur_pkg::ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, vic_wide[lrur_pkg::FRAME_W-1:0]};
                    m_tuser_next  = {res_error_reg, res_found_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lrur_pkg::ST_CLEAR;
            oldest_reg   <= '0;
            newest_reg   <= '0;
            empty_reg    <= 1'b1;
            fresh_reg    <= '0;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            newest_reg   <= newest_next;
            empty_reg    <= empty_next;
            fresh_reg    <= fresh_next;
            clr_idx_reg  <= clr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        op_frame_reg   <= op_frame_next;
        op_append_reg  <= op_append_next;
        res_victim_reg <= res_victim_next;
        res_found_reg  <= res_found_next;
        res_error_reg  <= res_error_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (st_we) state_mem[st_waddr] <= st_wdata;
        if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
        if (next_we) next_mem[next_waddr] <= next_wdata;
        if (rd_en) begin
            st_rd_reg   <= state_mem[op_frame_reg];
            prev_rd_reg <= prev_mem[op_frame_reg];
            next_rd_reg <= next_mem[op_frame_reg];
        end
    end

endmodule

// ===== rtl/lrur_checker.sv =====
// Port-level checker for the LRU frame replacer, bound to the top level.
module lrur_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // one word in flight: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready stayed high after accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output word changed");

    a_found_error_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and error both set");

    a_no_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("victim field nonzero without found");

endmodule

bind lru_replacer_with_pin_counts_core lrur_checker u_lrur_checker (.*);

// ===== sim/lrur_result_checker.sv =====
// Result checker for the LRU frame replacer: predicts each result word and compares it.
module lrur_result_checker #(
    parameter int FRAMES   = 64,
    parameter int PIN_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [5:0] frame, [7:6] zero
    input  logic [1:0] s_tuser,   // [1:0] func
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [5:0] victim_frame, [7:6] zero
    input  logic [1:0] m_tuser,   // [0] found, [1] error
    output int         fail_count,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [lrur_pkg::FRAME_W-1:0] frame;
        logic                         found;
        logic                         error;
    } victim_word_t;

    localparam logic [PIN_BITS-1:0] PIN_LIMIT = '1;
    localparam int unsigned EXP_DEPTH = 16;

    logic [PIN_BITS-1:0]          pins   [FRAMES];
    logic [lrur_pkg::FRAME_W-1:0] older  [FRAMES];
    logic [lrur_pkg::FRAME_W-1:0] newer  [FRAMES];
    bit                           listed [FRAMES];
    logic [lrur_pkg::FRAME_W-1:0] lru_head;
    logic [lrur_pkg::FRAME_W-1:0] lru_tail;
    bit                           order_empty;
    int unsigned                  fresh_next;
    victim_word_t                 exp_mem [EXP_DEPTH];
    int unsigned                  exp_rd;
    int unsigned                  exp_wr;
    int unsigned                  exp_cnt;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        exp_rd      = 0;
        exp_wr      = 0;
        exp_cnt     = 0;
    end

    task automatic drop_from_order(input logic [lrur_pkg::FRAME_W-1:0] f);
        logic [lrur_pkg::FRAME_W-1:0] p;
        logic [lrur_pkg::FRAME_W-1:0] n;
        p = older[f];
        n = newer[f];
        if (f == lru_head && f == lru_tail) begin
            order_empty = 1'b1;
            lru_head    = '0;
            lru_tail    = '0;
        end else if (f == lru_head) begin
            lru_head = n;
            older[n] = '0;
        end else if (f == lru_tail) begin
            lru_tail = p;
            newer[p] = '0;
        end else begin
            newer[p] = n;
            older[n] = p;
        end
        older[f]  = '0;
        newer[f]  = '0;
        listed[f] = 1'b0;
    endtask

    task automatic add_newest(input logic [lrur_pkg::FRAME_W-1:0] f);
        if (order_empty) begin
            lru_head    = f;
            lru_tail    = f;
            older[f]    = '0;
            order_empty = 1'b0;
        end else begin
            newer[lru_tail] = f;
            older[f]        = lru_tail;
            lru_tail        = f;
        end
        newer[f]  = '0;
        listed[f] = 1'b1;
    endtask

    task automatic predict_word(input lrur_pkg::func_t op,
                                input logic [lrur_pkg::FRAME_W-1:0] f,
                                output victim_word_t w);
        w = '0;
        case (op)
            lrur_pkg::FUNC_VICTIM: begin
                if (fresh_next < FRAMES) begin
                    w.frame = lrur_pkg::FRAME_W'(fresh_next);
                    w.found = 1'b1;
                    fresh_next++;
                end else if (!order_empty) begin
                    w.frame = lru_head;
                    w.found = 1'b1;
                    drop_from_order(lru_head);
                end
            end
            lrur_pkg::FUNC_PIN: begin
                if (int'(f) < FRAMES) begin
                    if (pins[f] == PIN_LIMIT) begin
                        w.error = 1'b1;
                    end else begin
                        if (pins[f] == '0 && listed[f])
                            drop_from_order(f);
                        pins[f]++;
                    end
                end
            end
            lrur_pkg::FUNC_UNPIN: begin
                if (int'(f) < FRAMES) begin
                    if (pins[f] == '0) begin
                        w.error = 1'b1;
                    end else begin
                        pins[f]--;
                        if (pins[f] == '0 && !listed[f])
                            add_newest(f);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        victim_word_t want;
        victim_word_t got;
        if (!aresetn) begin
            for (int i = 0; i < FRAMES; i++) begin
                pins[i]   = '0;
                older[i]  = '0;
                newer[i]  = '0;
                listed[i] = 1'b0;
            end
            lru_head    = '0;
            lru_tail    = '0;
            order_empty = 1'b1;
            fresh_next  = 0;
            exp_rd      = 0;
            exp_wr      = 0;
            exp_cnt     = 0;
        end else begin
            // result side first: a word taken at this edge belongs to an older input word
            if (m_tvalid && m_tready) begin
                got.frame = m_tdata[lrur_pkg::FRAME_W-1:0];
                got.found = m_tuser[0];
                got.error = m_tuser[1];
                if (exp_cnt == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word tdata=%h tuser=%b",
                                 $time, m_tdata, m_tuser);
                end else begin
                    want    = exp_mem[exp_rd];
                    exp_rd  = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (got !== want || m_tdata[7:lrur_pkg::FRAME_W] !== '0) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result word differs: expected frame=%0d found=%b ",
                                      "error=%b, got tdata=%h found=%b error=%b"},
                                     $time, want.frame, want.found, want.error,
                                     m_tdata, got.found, got.error);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_word(lrur_pkg::func_t'(s_tuser),
                             s_tdata[lrur_pkg::FRAME_W-1:0], want);
                if (exp_cnt == EXP_DEPTH) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: too many input words without a result", $time);
                end else begin
                    exp_mem[exp_wr] = want;
                    exp_wr          = (exp_wr + 1) % EXP_DEPTH;
                    exp_cnt++;
                end
            end
        end
        outstanding <= int'(exp_cnt);
    end

endmodule

// ===== sim/lru_replacer_with_pin_counts_core_tb.sv =====
// Testbench top for the LRU frame replacer: drives operation words and gives the verdict.
module lru_replacer_with_pin_counts_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES      = 64;
    localparam int PIN_BITS    = 8;
    localparam int PIN_LIMIT   = (1 << PIN_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int held [FRAMES];
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int rx_hold_left = 0;

    lru_replacer_with_pin_counts_core #(
        .FRAMES   (FRAMES),
        .PIN_BITS (PIN_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lrur_result_checker #(
        .FRAMES   (FRAMES),
        .PIN_BITS (PIN_BITS)
    ) victim_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("lru_replacer_with_pin_counts_core: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // hot set of low frames so the order list gets reused
    function automatic logic [lrur_pkg::FRAME_W-1:0] pick_frame();
        if ($urandom_range(0, 9) < 6)
            return lrur_pkg::FRAME_W'($urandom_range(0, 7));
        return lrur_pkg::FRAME_W'($urandom_range(0, FRAMES - 1));
    endfunction

    function automatic logic [lrur_pkg::FRAME_W-1:0] pinned_frame();
        logic [lrur_pkg::FRAME_W-1:0] f;
        f = pick_frame();
        for (int k = 0; k < 8 && held[f] == 0; k++)
            f = pick_frame();
        return f;
    endfunction

    task automatic put_word(input lrur_pkg::func_t op,
                            input logic [lrur_pkg::FRAME_W-1:0] fr);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, fr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == lrur_pkg::FUNC_PIN && held[fr] < PIN_LIMIT)
            held[fr]++;
        if (op == lrur_pkg::FUNC_UNPIN && held[fr] > 0)
            held[fr]--;
        if (tx_gaps_on && $urandom_range(0, 99) >= 50) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // result side: random stalls plus the long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                stall = gap_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        for (int i = 0; i < FRAMES; i++)
            held[i] = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= lrur_pkg::FUNC_NOP;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: error on zero count, order list, fresh hand-out of listed frames, nop
        put_word(lrur_pkg::FUNC_UNPIN, 0);
        put_word(lrur_pkg::FUNC_PIN, 63);
        put_word(lrur_pkg::FUNC_PIN, 63);
        put_word(lrur_pkg::FUNC_UNPIN, 63);
        put_word(lrur_pkg::FUNC_UNPIN, 63);
        put_word(lrur_pkg::FUNC_PIN, 0);
        put_word(lrur_pkg::FUNC_UNPIN, 0);
        put_word(lrur_pkg::FUNC_NOP, 63);
        put_word(lrur_pkg::FUNC_NOP, 0);
        put_word(lrur_pkg::FUNC_PIN, 5);
        put_word(lrur_pkg::FUNC_VICTIM, 63);
        put_word(lrur_pkg::FUNC_VICTIM, 0);
        put_word(lrur_pkg::FUNC_VICTIM, 42);
        put_word(lrur_pkg::FUNC_PIN, 0);
        put_word(lrur_pkg::FUNC_UNPIN, 0);
        put_word(lrur_pkg::FUNC_UNPIN, 5);
        put_word(lrur_pkg::FUNC_UNPIN, 5);
        put_word(lrur_pkg::FUNC_PIN, 63);
        put_word(lrur_pkg::FUNC_UNPIN, 63);

        // count saturation on one frame, back-to-back words
        tx_gaps_on = 1'b0;
        for (int i = 0; i <= PIN_LIMIT; i++)
            put_word(lrur_pkg::FUNC_PIN, 9);
        for (int i = 0; i < 4; i++)
            put_word(lrur_pkg::FUNC_UNPIN, 9);
        tx_gaps_on = 1'b1;

        for (int n = 0; n < 250; n++) begin
            if (n == 60) begin
                rx_hold_left = 300;
                tx_gaps_on   = 1'b0;
            end
            if (n == 90)
                tx_gaps_on = 1'b1;
            if (n == 140)
                wait_drained();
            if (n == 180) begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end
            if (n == 220) begin
                tx_gaps_on = 1'b1;
                rx_gaps_on = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 30)
                put_word(lrur_pkg::FUNC_VICTIM,
                         lrur_pkg::FRAME_W'($urandom_range(0, FRAMES - 1)));
            else if (r < 60)
                put_word(lrur_pkg::FUNC_PIN, pick_frame());
            else if (r < 92)
                put_word(lrur_pkg::FUNC_UNPIN, pinned_frame());
            else if (r < 96)
                put_word(lrur_pkg::FUNC_NOP,
                         lrur_pkg::FRAME_W'($urandom_range(0, FRAMES - 1)));
            else
                put_word(lrur_pkg::FUNC_UNPIN,
                         lrur_pkg::FRAME_W'($urandom_range(0, FRAMES - 1)));
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("lru_replacer_with_pin_counts_core: match");
        else
            $display("lru_replacer_with_pin_counts_core: mismatch");
        $finish;
    end

endmodule

// ===== lru_replacer_with_pin_counts_core.f =====
rtl/lrur_pkg.sv
rtl/lru_replacer_with_pin_counts_core.sv
rtl/lrur_checker.sv
sim/lrur_result_checker.sv
sim/lru_replacer_with_pin_counts_core_tb.sv
